### sv/box_downsample_rgba16_top_macros.svh
// ----------------------------------------------------------------------------
// Box downsample assertion macros
// Concurrent checks clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_RGBA16_TOP_MACROS_SVH
`define BOX_DOWNSAMPLE_RGBA16_TOP_MACROS_SVH

// same-cycle implication
`define BDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box downsample package
// Shared widths, item types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package bds_pkg;

   localparam int MAX_SRC_WIDTH = 4096;
   localparam int IDX_W         = $clog2(MAX_SRC_WIDTH);
   localparam int POS_W         = 12;
   localparam int LOG2_W        = 4;
   localparam int SHIFT_W       = 5;
   localparam int CHAN_W        = 16;
   localparam int SUM_W         = 40;
   localparam logic [LOG2_W-1:0] LOG2_LIMIT = 4'd12;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 16'hFFFF;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SRC_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_DEST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DEST_HEIGHT = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_g;
      logic [CHAN_W-1:0] chan_r;
   } pix_type;

   typedef struct packed {
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] r;
   } sum_type;

   typedef struct packed {
      logic               first;
      logic               emit;
      logic               row_end;
      logic               frame_end;
      logic [SHIFT_W-1:0] shift;
   } ctl_type;

   function automatic logic [LOG2_W-1:0] sat_log2(input logic [LOG2_W-1:0] v);
      return (v > LOG2_LIMIT) ? LOG2_LIMIT : v;
   endfunction

   function automatic logic [LOG2_W-1:0] ratio_log2(input logic [LOG2_W-1:0] src,
                                                    input logic [LOG2_W-1:0] dst);
      logic [LOG2_W-1:0] s;
      logic [LOG2_W-1:0] d;
      s = sat_log2(src);
      d = sat_log2(dst);
      return (d > s) ? '0 : LOG2_W'(s - d);
   endfunction

   // low mask of 2^n - 1 over a position
   function automatic logic [POS_W-1:0] low_mask(input logic [LOG2_W-1:0] n);
      logic [POS_W:0] one_hot;
      one_hot = (POS_W+1)'(1) << n;
      return POS_W'(one_hot - (POS_W+1)'(1));
   endfunction

   function automatic logic [CHAN_W-1:0] block_mean(input logic [SUM_W-1:0] sum,
                                                    input logic [SHIFT_W-1:0] sh);
      logic [SUM_W-1:0] m;
      m = sum >> sh;
      return (m > SUM_W'(CHAN_MAX)) ? CHAN_MAX : m[CHAN_W-1:0];
   endfunction

endpackage

### sv/box_downsample_rgba16_top.sv
`timescale 1ns / 1ps
// After its last source pixel is accepted, a result passes s1, the write stage and rsp_data_ff.
// Throughput: one pixel per cycle; the accumulator RAM read-add-write path is forwarded.
// The pipeline halts only while a result waits in the rsp register with rsp_tready low.
// Reset clears positions, registers and valid flags; the accumulator RAM is not cleared,
// since the first pixel of each block discards the stored entry and overwrites it.
// ----------------------------------------------------------------------------
// Box downsample RGBA16 top level
// Power-of-two box filter shrink of a raster stream of 16-bit RGBA pixels.
// ----------------------------------------------------------------------------
module box_downsample_rgba16_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // chan_r, chan_g, chan_b, chan_a
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_r, out_g, out_b, out_a
   output logic        rsp_tlast,   // row_end
   output logic        rsp_tuser,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);

   logic [bds_pkg::LOG2_W-1:0] src_w_ff;
   logic [bds_pkg::LOG2_W-1:0] src_h_ff;
   logic [bds_pkg::LOG2_W-1:0] dst_w_ff;
   logic [bds_pkg::LOG2_W-1:0] dst_h_ff;
   logic [bds_pkg::POS_W-1:0]  col_pos_ff;
   logic [bds_pkg::POS_W-1:0]  row_pos_ff;
   logic [bds_pkg::POS_W-1:0]  col_pos_in;
   logic [bds_pkg::POS_W-1:0]  row_pos_in;

   logic                       adv;
   logic                       accept;
   logic [bds_pkg::LOG2_W-1:0] rx;
   logic [bds_pkg::LOG2_W-1:0] ry;
   logic [bds_pkg::POS_W-1:0]  wmask;
   logic [bds_pkg::POS_W-1:0]  hmask;
   logic [bds_pkg::POS_W-1:0]  mx;
   logic [bds_pkg::POS_W-1:0]  my;
   logic [bds_pkg::POS_W-1:0]  col;
   logic [bds_pkg::POS_W-1:0]  row;
   logic [bds_pkg::POS_W-1:0]  col_blk;
   bds_pkg::ctl_type           in_ctl;

   logic                       s2_valid;
   bds_pkg::ctl_type           s2_ctl;
   bds_pkg::sum_type           s2_sum;

   logic                       rsp_valid_ff;
   logic [63:0]                rsp_data_ff;
   logic                       rsp_last_ff;
   logic                       rsp_user_ff;

   // advance everything unless a result is held at the output
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_comb begin
      rx      = bds_pkg::ratio_log2(src_w_ff, dst_w_ff);
      ry      = bds_pkg::ratio_log2(src_h_ff, dst_h_ff);
      wmask   = bds_pkg::low_mask(bds_pkg::sat_log2(src_w_ff));
      hmask   = bds_pkg::low_mask(bds_pkg::sat_log2(src_h_ff));
      mx      = bds_pkg::low_mask(rx);
      my      = bds_pkg::low_mask(ry);
      col     = col_pos_ff & wmask;
      row     = row_pos_ff & hmask;
      col_blk = col >> rx;
      in_ctl.first     = ((col & mx) == '0) && ((row & my) == '0);
      in_ctl.emit      = ((col & mx) == mx) && ((row & my) == my);
      in_ctl.row_end   = (col == wmask);
      in_ctl.frame_end = (col == wmask) && (row == hmask);
      in_ctl.shift     = bds_pkg::SHIFT_W'(rx) + bds_pkg::SHIFT_W'(ry);
      if (col == wmask) begin
         col_pos_in = '0;
         row_pos_in = (row == hmask) ? '0 : row + bds_pkg::POS_W'(1);
      end else begin
         col_pos_in = col + bds_pkg::POS_W'(1);
         row_pos_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= '0;
         src_h_ff <= '0;
         dst_w_ff <= '0;
         dst_h_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            bds_pkg::CSR_SRC_WIDTH:   src_w_ff <= csr_wdata;
            bds_pkg::CSR_SRC_HEIGHT:  src_h_ff <= csr_wdata;
            bds_pkg::CSR_DEST_WIDTH:  dst_w_ff <= csr_wdata;
            bds_pkg::CSR_DEST_HEIGHT: dst_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a register write starts a new frame
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   bds_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept),
      .in_idx    (col_blk[bds_pkg::IDX_W-1:0]),
      .in_pix    (bds_pkg::pix_type'(req_tdata)),
      .in_ctl    (in_ctl),
      .out_valid (s2_valid),
      .out_ctl   (s2_ctl),
      .out_sum   (s2_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid && s2_ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {bds_pkg::block_mean(s2_sum.a, s2_ctl.shift),
                         bds_pkg::block_mean(s2_sum.b, s2_ctl.shift),
                         bds_pkg::block_mean(s2_sum.g, s2_ctl.shift),
                         bds_pkg::block_mean(s2_sum.r, s2_ctl.shift)};
         rsp_last_ff <= s2_ctl.row_end;
         rsp_user_ff <= s2_ctl.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### sv/bds_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box downsample column accumulator
// One RAM entry per output column; read, add, write back with forwarding.
// ----------------------------------------------------------------------------
`include "box_downsample_rgba16_top_macros.svh"

module bds_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [bds_pkg::IDX_W-1:0] in_idx,
   input  bds_pkg::pix_type         in_pix,
   input  bds_pkg::ctl_type         in_ctl,
   output logic                     out_valid,
   output bds_pkg::ctl_type         out_ctl,
   output bds_pkg::sum_type         out_sum
);

   bds_pkg::sum_type mem [bds_pkg::MAX_SRC_WIDTH];

   bds_pkg::sum_type                rd_data_ff;
   logic                            s1_valid_ff;
   logic [bds_pkg::IDX_W-1:0]       s1_idx_ff;
   bds_pkg::pix_type                s1_pix_ff;
   bds_pkg::ctl_type                s1_ctl_ff;

   logic                            wr_valid_ff;
   logic [bds_pkg::IDX_W-1:0]       wr_idx_ff;
   bds_pkg::ctl_type                wr_ctl_ff;
   bds_pkg::sum_type                wr_sum_ff;

   logic                            fwd;
   bds_pkg::sum_type                base;
   bds_pkg::sum_type                wr_sum_in;

   // the read issued alongside the previous write returned stale data
   assign fwd = wr_valid_ff && (wr_idx_ff == s1_idx_ff);

   always_comb begin
      if (s1_ctl_ff.first) begin
         base = '0;
      end else if (fwd) begin
         base = wr_sum_ff;
      end else begin
         base = rd_data_ff;
      end
      wr_sum_in.r = base.r + bds_pkg::SUM_W'(s1_pix_ff.chan_r);
      wr_sum_in.g = base.g + bds_pkg::SUM_W'(s1_pix_ff.chan_g);
      wr_sum_in.b = base.b + bds_pkg::SUM_W'(s1_pix_ff.chan_b);
      wr_sum_in.a = base.a + bds_pkg::SUM_W'(s1_pix_ff.chan_a);
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rd_data_ff <= mem[in_idx];
      end
      if (adv && s1_valid_ff) begin
         mem[s1_idx_ff] <= wr_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         wr_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff <= in_idx;
         s1_pix_ff <= in_pix;
         s1_ctl_ff <= in_ctl;
         wr_idx_ff <= s1_idx_ff;
         wr_ctl_ff <= s1_ctl_ff;
         wr_sum_ff <= wr_sum_in;
      end
   end

   assign out_valid = wr_valid_ff;
   assign out_ctl   = wr_ctl_ff;
   assign out_sum   = wr_sum_ff;

   `BDS_ASSERT_NEXT(a_stall_hold, !adv, $stable(wr_sum_ff), "stage two moved while stalled")
   `BDS_ASSERT_NOW(a_first_narrow, wr_valid_ff && wr_ctl_ff.first, wr_sum_ff.r[39:16] == '0, "first pixel sum wider than a channel")
   `BDS_ASSERT_NOW(a_frame_row, wr_valid_ff && wr_ctl_ff.frame_end, wr_ctl_ff.row_end && wr_ctl_ff.emit, "frame end without row end")
   `BDS_ASSERT_NEXT(a_fwd_track, adv && s1_valid_ff, wr_valid_ff && (wr_idx_ff == $past(s1_idx_ff)), "forward stage lost its index")

endmodule

### sim/box_mean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box downsample result checker
// Follows the csr port and the accepted req pixels, keeps its own column sums,
// predicts each block mean and compares every accepted rsp item with the
// oldest prediction.
// ----------------------------------------------------------------------------
module box_mean_checker
   import bds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // chan_r, chan_g, chan_b, chan_a
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // out_r, out_g, out_b, out_a
   input  logic        rsp_tlast,   // row_end
   input  logic        rsp_tuser,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [3:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic                   row_end;
      logic                   frame_end;
      logic [3:0][CHAN_W-1:0] mean;
   } block_mean_type;

   logic [LOG2_W-1:0] log2_reg [4];
   logic [SUM_W-1:0]  col_sum  [4][MAX_SRC_WIDTH];
   int                col_pos;
   int                row_pos;
   block_mean_type    mean_queue [$];
   string             chan_name [4];

   initial begin
      fail_count   = 0;
      pending      = 0;
      checked      = 0;
      chan_name[0] = "out_r";
      chan_name[1] = "out_g";
      chan_name[2] = "out_b";
      chan_name[3] = "out_a";
   end

   function automatic int clip_log2(input logic [LOG2_W-1:0] v);
      return (v > LOG2_LIMIT) ? int'(LOG2_LIMIT) : int'(v);
   endfunction

   // destination above source means no shrink on that axis
   function automatic int shrink_log2(input logic [LOG2_W-1:0] src,
                                      input logic [LOG2_W-1:0] dst);
      int s;
      int d;
      s = clip_log2(src);
      d = clip_log2(dst);
      return (d > s) ? 0 : s - d;
   endfunction

   function automatic logic [CHAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                 input int shift);
      logic [SUM_W-1:0] m;
      m = sum >> shift;
      return (m > SUM_W'(CHAN_MAX)) ? CHAN_MAX : m[CHAN_W-1:0];
   endfunction

   task automatic accumulate(input pix_type px);
      int                     wl;
      int                     hl;
      int                     rx;
      int                     ry;
      int                     width;
      int                     height;
      int                     mx;
      int                     my;
      int                     col;
      int                     row;
      int                     idx;
      logic [3:0][CHAN_W-1:0] chan;
      block_mean_type         res;
      wl     = clip_log2(log2_reg[CSR_SRC_WIDTH]);
      hl     = clip_log2(log2_reg[CSR_SRC_HEIGHT]);
      rx     = shrink_log2(log2_reg[CSR_SRC_WIDTH], log2_reg[CSR_DEST_WIDTH]);
      ry     = shrink_log2(log2_reg[CSR_SRC_HEIGHT], log2_reg[CSR_DEST_HEIGHT]);
      width  = 1 << wl;
      height = 1 << hl;
      mx     = (1 << rx) - 1;
      my     = (1 << ry) - 1;
      col    = col_pos & (width - 1);
      row    = row_pos & (height - 1);
      idx    = (col >> rx) % MAX_SRC_WIDTH;
      chan   = px;
      // first pixel of a block overwrites the column sum
      for (int c = 0; c < 4; c++) begin
         if ((col & mx) == 0 && (row & my) == 0)
            col_sum[c][idx] = SUM_W'(chan[c]);
         else
            col_sum[c][idx] = col_sum[c][idx] + SUM_W'(chan[c]);
      end
      if ((col & mx) == mx && (row & my) == my) begin
         for (int c = 0; c < 4; c++)
            res.mean[c] = mean_of(col_sum[c][idx], rx + ry);
         res.row_end   = (col == width - 1);
         res.frame_end = (col == width - 1) && (row == height - 1);
         mean_queue.push_back(res);
      end
      if (col == width - 1) begin
         col_pos = 0;
         row_pos = (row == height - 1) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endtask

   task automatic compare_result();
      block_mean_type         want;
      logic [3:0][CHAN_W-1:0] got;
      got = rsp_tdata;
      if (mean_queue.size() == 0) begin
         $error("rsp item with no pending block mean: tdata %h", rsp_tdata);
         fail_count++;
         return;
      end
      want = mean_queue.pop_front();
      checked++;
      for (int c = 0; c < 4; c++) begin
         if (got[c] !== want.mean[c]) begin
            $error("%s mismatch: expected %0d, actual %0d", chan_name[c], want.mean[c],
                   got[c]);
            fail_count++;
         end
      end
      if (rsp_tlast !== want.row_end) begin
         $error("row_end mismatch: expected %0d, actual %0d", want.row_end, rsp_tlast);
         fail_count++;
      end
      if (rsp_tuser !== want.frame_end) begin
         $error("frame_end mismatch: expected %0d, actual %0d", want.frame_end, rsp_tuser);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++)
            log2_reg[i] = '0;
         col_pos = 0;
         row_pos = 0;
         mean_queue.delete();
      end else begin
         // a register write restarts the frame, sums are kept
         if (csr_we) begin
            log2_reg[csr_addr] = csr_wdata;
            col_pos = 0;
            row_pos = 0;
         end
         if (req_tvalid && req_tready)
            accumulate(pix_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            compare_result();
      end
      pending = mean_queue.size();
   end

endmodule

### sim/tb_box_downsample_rgba16_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box downsample RGBA16 testbench
// Drives directed and random pixel streams through a series of size settings
// with random stalls on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_box_downsample_rgba16_top;
   import bds_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 650;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [3:0]  csr_wdata  = '0;

   int fail_count;
   int pending;
   int checked;
   int sent_items   = 0;
   int random_items = 0;
   int setting_cnt  = 0;
   int ready_hold   = 0;
   bit burst        = 1'b0;

   always #2 clock = ~clock;

   box_downsample_rgba16_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   box_mean_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 1) == 1) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 60);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= idle_len() - 1;
      end
   end

   function automatic pix_type mk_pixel(input logic [15:0] r, input logic [15:0] g,
                                        input logic [15:0] b, input logic [15:0] a);
      pix_type px;
      px.chan_r = r;
      px.chan_g = g;
      px.chan_b = b;
      px.chan_a = a;
      return px;
   endfunction

   function automatic logic [15:0] random_chan();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return 16'h0000;
      else if (roll < 30)
         return CHAN_MAX;
      return 16'($urandom);
   endfunction

   function automatic pix_type random_pixel();
      return mk_pixel(random_chan(), random_chan(), random_chan(), random_chan());
   endfunction

   // hold the item until accepted; gaps lower tvalid first
   task automatic send_pixel(input pix_type px);
      int gap;
      gap = (burst || $urandom_range(0, 99) < 60) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // stop sending, wait for every block mean and let the pipeline empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] addr, input logic [3:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [3:0] sw, input logic [3:0] sh,
                            input logic [3:0] dw, input logic [3:0] dh);
      drain();
      csr_write(CSR_SRC_WIDTH, sw);
      csr_write(CSR_SRC_HEIGHT, sh);
      csr_write(CSR_DEST_WIDTH, dw);
      csr_write(CSR_DEST_HEIGHT, dh);
      csr_we <= 1'b0;
      setting_cnt++;
   endtask

   initial begin
      int sw;
      int sh;
      int dw;
      int dh;
      int frame_px;
      int count;
      int hold_at;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 1x1 frame after reset: every pixel is its own mean and ends the frame
      send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_pixel(mk_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
      send_pixel(mk_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_pixel(mk_pixel(16'hAAAA, 16'h5555, 16'h0001, 16'h8000));

      // 2x2 into one pixel: full-scale block, then one that truncates
      configure(4'd1, 4'd1, 4'd0, 4'd0);
      repeat (4) send_pixel(mk_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
      for (int i = 0; i < 4; i++)
         send_pixel(mk_pixel(16'(i), 16'(3 * i + 1), 16'(CHAN_MAX - i), 16'(16'h8000 + i)));

      // destination above source: no shrink
      configure(4'd1, 4'd0, 4'd3, 4'd2);
      repeat (2) send_pixel(random_pixel());

      // saturating destination values
      configure(4'd2, 4'd0, 4'd15, 4'd13);
      repeat (4) send_pixel(random_pixel());

      // rewrite a register mid-frame: positions restart, next block starts clean
      configure(4'd1, 4'd1, 4'd0, 4'd0);
      repeat (2) send_pixel(random_pixel());
      drain();
      csr_write(CSR_DEST_WIDTH, 4'd0);
      csr_we <= 1'b0;
      repeat (4) send_pixel(random_pixel());

      // saturated source sizes: a cut 4096-wide row, then 64-wide full-scale blocks
      configure(4'd14, 4'd0, 4'd12, 4'd0);
      repeat (64) send_pixel(random_pixel());
      configure(4'd15, 4'd13, 4'd6, 4'd15);
      repeat (128) send_pixel(mk_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));

      while (random_items < RANDOM_ITEMS) begin
         sw = $urandom_range(0, 4);
         sh = $urandom_range(0, 6 - sw > 4 ? 4 : 6 - sw);
         dw = ($urandom_range(0, 4) != 0) ? $urandom_range(0, sw) : $urandom_range(sw, 15);
         dh = ($urandom_range(0, 4) != 0) ? $urandom_range(0, sh) : $urandom_range(sh, 15);
         configure(4'(sw), 4'(sh), 4'(dw), 4'(dh));
         burst    = ($urandom_range(0, 3) == 0);
         frame_px = 1 << (sw + sh);
         count    = frame_px * $urandom_range(1, 3);
         // now and then cut the frame short
         if ($urandom_range(0, 6) == 0)
            count = $urandom_range(1, frame_px);
         hold_at = (random_items == 0 || $urandom_range(0, 4) == 0) ?
                   $urandom_range(0, count - 1) : -1;
         for (int i = 0; i < count; i++) begin
            if (i == hold_at)
               drain();
            send_pixel(random_pixel());
         end
         random_items += count;
      end
      burst = 1'b0;

      drain();
      $display("Sent %0d pixels under %0d size settings, %0d block means checked",
               sent_items, setting_cnt, checked);
      $display("Covered 1x1 frames, saturated 4096-wide sizes, oversize destinations, cut frames");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timeout with %0d block means outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/bds_pkg.sv
sv/bds_accum.sv
sv/box_downsample_rgba16_top.sv
sim/box_mean_checker.sv
sim/tb_box_downsample_rgba16_top.sv
